// ----- rtl/crc8sfp_pkg.sv -----
// Package for the CRC-8 serial frame parser.
// Holds the header and command constants, the CRC-8 byte step and the
// structs passed between the input stage, the parser and the result register.
package crc8sfp_pkg;

   // Frame constants.
   localparam logic [7:0] HEADER_BYTE_ONE = 8'hAA;
   localparam logic [7:0] HEADER_BYTE_TWO = 8'h55;
   localparam logic [7:0] SUBCMD_BATTERY  = 8'h04;
   localparam logic [7:0] FUNCTION_SYSTEM = 8'h00;
   localparam logic [7:0] EMPTY_PAYLOAD   = 8'hFF;
   localparam logic [7:0] CRC_POLY_REFL   = 8'h8C;
   localparam logic [7:0] BATTERY_MIN_LEN = 8'd3;
   localparam int unsigned HEAD_DEPTH     = 3;

   // Configuration register indexes.
   localparam logic CSR_RX_ENABLE      = 1'b0;
   localparam logic CSR_FUNCTION_LIMIT = 1'b1;

   // Register reset values.
   localparam logic       RX_ENABLE_RESET      = 1'b1;
   localparam logic [7:0] FUNCTION_LIMIT_RESET = 8'hFF;

   // One received byte waiting in the input register.
   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } item_type;

   // One frame report.
   typedef struct packed {
      logic [7:0]  frame_function;
      logic [7:0]  frame_length;
      logic        crc_ok;
      logic [7:0]  first_payload;
      logic        battery_update;
      logic [15:0] battery_millivolts;
   } report_type;

   // CRC-8 (reflected 0x31, no final xor) advanced by one byte.
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ----- rtl/crc8sfp_in_stage.sv -----
// Input register of the CRC-8 serial frame parser.
// Holds one received byte until the parser takes it; uses crc8sfp_pkg.
module crc8sfp_in_stage
   import crc8sfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       advance,
   output item_type   item
);

   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       accept;

   // The register is free when empty or when its item moves on this cycle.
   assign req_stall = valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (accept) begin
         valid_in = 1'b1;
         data_in  = req_rx_byte;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign item.valid = valid_ff;
   assign item.data  = data_ff;

endmodule

// ----- rtl/crc8sfp_parser.sv -----
// Frame parser state machine of the CRC-8 serial frame parser.
// Holds the configuration registers, the parse state, the running CRC and the
// battery store; builds one report per checksum byte. Uses crc8sfp_pkg.
module crc8sfp_parser
   import crc8sfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   input  logic       csr_index,
   input  logic [7:0] csr_data,
   input  item_type   item,
   input  logic       advance,
   output logic       rsp_load,
   output report_type report
);

   typedef enum logic [2:0] {
      PH_HUNT1 = 3'd0,
      PH_HUNT2 = 3'd1,
      PH_FUNC  = 3'd2,
      PH_LEN   = 3'd3,
      PH_DATA  = 3'd4,
      PH_CHECK = 3'd5
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic        rx_enable_ff, rx_enable_in;
   logic [7:0]  function_limit_ff, function_limit_in;
   logic [7:0]  function_code_ff, function_code_in;
   logic [7:0]  payload_length_ff, payload_length_in;
   logic [7:0]  bytes_received_ff, bytes_received_in;
   logic [7:0]  running_crc_ff, running_crc_in;
   logic [7:0]  payload_head_ff [HEAD_DEPTH];
   logic [7:0]  payload_head_in [HEAD_DEPTH];
   logic [15:0] battery_store_ff, battery_store_in;

   logic       work;
   logic [7:0] b;
   logic [7:0] crc_next;
   logic [7:0] count_next;
   logic       crc_ok;
   logic       battery_hit;

   assign b    = item.data;
   assign work = item.valid && advance && rx_enable_ff;

   // The function byte starts a fresh CRC; later bytes extend it.
   assign crc_next   = crc8_byte((phase_ff == PH_FUNC) ? 8'd0 : running_crc_ff, b);
   assign count_next = bytes_received_ff + 8'd1;

   // Checksum test and battery frame recognition.
   assign crc_ok      = (b == running_crc_ff);
   assign battery_hit = crc_ok && (function_code_ff == FUNCTION_SYSTEM) &&
                        (payload_length_ff >= BATTERY_MIN_LEN) &&
                        (payload_head_ff[0] == SUBCMD_BATTERY);

   // Configuration writes.
   always_comb begin
      rx_enable_in      = rx_enable_ff;
      function_limit_in = function_limit_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_RX_ENABLE:      rx_enable_in      = csr_data[0];
            CSR_FUNCTION_LIMIT: function_limit_in = csr_data;
            default:            ;
         endcase
      end
   end

   // Next parse state for the byte being taken.
   always_comb begin
      phase_in          = phase_ff;
      function_code_in  = function_code_ff;
      payload_length_in = payload_length_ff;
      bytes_received_in = bytes_received_ff;
      running_crc_in    = running_crc_ff;
      payload_head_in   = payload_head_ff;
      battery_store_in  = battery_store_ff;
      rsp_load          = 1'b0;
      if (work) begin
         unique case (phase_ff)
            PH_HUNT2: begin
               phase_in = (b == HEADER_BYTE_TWO) ? PH_FUNC : PH_HUNT1;
            end
            PH_FUNC: begin
               if (b < function_limit_ff) begin
                  function_code_in = b;
                  running_crc_in   = crc_next;
                  phase_in         = PH_LEN;
               end else begin
                  phase_in = PH_HUNT1;
               end
            end
            PH_LEN: begin
               payload_length_in = b;
               bytes_received_in = 8'd0;
               running_crc_in    = crc_next;
               phase_in          = (b == 8'd0) ? PH_CHECK : PH_DATA;
            end
            PH_DATA: begin
               if (bytes_received_ff < BATTERY_MIN_LEN) begin
                  payload_head_in[bytes_received_ff[1:0]] = b;
               end
               running_crc_in    = crc_next;
               bytes_received_in = count_next;
               if (count_next >= payload_length_ff) begin
                  phase_in = PH_CHECK;
               end
            end
            PH_CHECK: begin
               if (battery_hit) begin
                  battery_store_in = {payload_head_ff[2], payload_head_ff[1]};
               end
               rsp_load = 1'b1;
               phase_in = PH_HUNT1;
            end
            default: begin
               phase_in = (b == HEADER_BYTE_ONE) ? PH_HUNT2 : PH_HUNT1;
            end
         endcase
      end
   end

   // Report for the checksum byte.
   always_comb begin
      report.frame_function     = function_code_ff;
      report.frame_length       = payload_length_ff;
      report.crc_ok             = crc_ok;
      report.first_payload      = (payload_length_ff != 8'd0) ? payload_head_ff[0]
                                                               : EMPTY_PAYLOAD;
      report.battery_update     = battery_hit;
      report.battery_millivolts = battery_store_in;
   end

   // State and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_HUNT1;
         rx_enable_ff      <= RX_ENABLE_RESET;
         function_limit_ff <= FUNCTION_LIMIT_RESET;
         function_code_ff  <= 8'd0;
         payload_length_ff <= 8'd0;
         bytes_received_ff <= 8'd0;
         running_crc_ff    <= 8'd0;
         battery_store_ff  <= 16'd0;
         for (int i = 0; i < HEAD_DEPTH; i++) begin
            payload_head_ff[i] <= 8'd0;
         end
      end else begin
         phase_ff          <= phase_in;
         rx_enable_ff      <= rx_enable_in;
         function_limit_ff <= function_limit_in;
         function_code_ff  <= function_code_in;
         payload_length_ff <= payload_length_in;
         bytes_received_ff <= bytes_received_in;
         running_crc_ff    <= running_crc_in;
         battery_store_ff  <= battery_store_in;
         payload_head_ff   <= payload_head_in;
      end
   end

`ifndef NO_ASSERTIONS
   // A report only comes from the checksum byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (phase_ff == PH_CHECK))
      else $error("report loaded outside the checksum phase");

   // After a report the parser hunts for a new header.
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (phase_ff == PH_HUNT1))
      else $error("parser did not return to the header hunt");

   // In the data phase the count never reaches the length.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (bytes_received_ff < payload_length_ff))
      else $error("payload count overran the length");
`endif

endmodule

// ----- rtl/crc8sfp_rsp_reg.sv -----
// Result register of the CRC-8 serial frame parser.
// Holds one frame report until the receiver takes it; uses crc8sfp_pkg.
module crc8sfp_rsp_reg
   import crc8sfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  report_type  report,
   output logic        advance,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_frame_function,
   output logic [7:0]  rsp_frame_length,
   output logic        rsp_crc_ok,
   output logic [7:0]  rsp_first_payload,
   output logic        rsp_battery_update,
   output logic [15:0] rsp_battery_millivolts
);

   logic       valid_ff, valid_in;
   report_type report_ff, report_in;

   // The parser may move when the register is empty or being emptied.
   assign advance = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in  = valid_ff;
      report_in = report_ff;
      if (load) begin
         valid_in  = 1'b1;
         report_in = report;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      report_ff <= report_in;
   end

   assign rsp_valid              = valid_ff;
   assign rsp_frame_function     = report_ff.frame_function;
   assign rsp_frame_length       = report_ff.frame_length;
   assign rsp_crc_ok             = report_ff.crc_ok;
   assign rsp_first_payload      = report_ff.first_payload;
   assign rsp_battery_update     = report_ff.battery_update;
   assign rsp_battery_millivolts = report_ff.battery_millivolts;

`ifndef NO_ASSERTIONS
   // A held report is never overwritten.
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rsp_stall) |-> !load)
      else $error("report overwritten while stalled");

   // A battery update needs a good checksum.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_battery_update) |-> rsp_crc_ok)
      else $error("battery update with bad checksum");

   // A battery update comes only from a system battery frame.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_battery_update) |->
         ((rsp_frame_function == FUNCTION_SYSTEM) &&
          (rsp_frame_length >= BATTERY_MIN_LEN) &&
          (rsp_first_payload == SUBCMD_BATTERY)))
      else $error("battery update from a non-battery frame");
`endif

endmodule

// ----- rtl/crc8_serial_frame_parser_unit.sv -----
// Serial frame parser with CRC-8: hunts for the 0xAA 0x55 header, takes a
// function code, a length and the payload, and reports each frame at its
// checksum byte. One byte is taken per clock cycle, sustained; a byte goes
// from the input register through the parser to the result register, so a
// report is registered in the result register when its checksum byte leaves
// the input register. The only limit on rate is a stalled result register,
// which holds the input register and stalls the byte channel. Configuration
// writes are taken in any cycle (csr_ready is always high). Depends on
// crc8sfp_pkg and the three submodules.
module crc8_serial_frame_parser_unit
   import crc8sfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Byte channel.
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   // Report channel.
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_frame_function,
   output logic [7:0]  rsp_frame_length,
   output logic        rsp_crc_ok,
   output logic [7:0]  rsp_first_payload,
   output logic        rsp_battery_update,
   output logic [15:0] rsp_battery_millivolts,
   // Configuration write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_data
);

   item_type   item;
   report_type report;
   logic       advance;
   logic       rsp_load;

   assign csr_ready = 1'b1;

   // Input register.
   crc8sfp_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .advance     (advance),
      .item        (item)
   );

   // Parser state machine.
   crc8sfp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .item      (item),
      .advance   (advance),
      .rsp_load  (rsp_load),
      .report    (report)
   );

   // Result register.
   crc8sfp_rsp_reg u_rsp_reg (
      .clock                  (clock),
      .reset                  (reset),
      .load                   (rsp_load),
      .report                 (report),
      .advance                (advance),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_frame_function     (rsp_frame_function),
      .rsp_frame_length       (rsp_frame_length),
      .rsp_crc_ok             (rsp_crc_ok),
      .rsp_first_payload      (rsp_first_payload),
      .rsp_battery_update     (rsp_battery_update),
      .rsp_battery_millivolts (rsp_battery_millivolts)
   );

endmodule

// ----- sim/tb_crc8_serial_frame_parser_unit.sv -----
// Self-checking testbench for crc8_serial_frame_parser_unit: a directed byte table, then
// random frames under four idle patterns and several register settings.
// Depends on crc8sfp_pkg and the parser RTL; every report is checked against a local model.
module tb_crc8_serial_frame_parser_unit;
   import crc8sfp_pkg::*;

   // Parser phases as tracked by the local model.
   typedef enum logic [2:0] {
      HUNT_FIRST, HUNT_SECOND, TAKE_FUNCTION, TAKE_LENGTH, TAKE_PAYLOAD, TAKE_CHECKSUM
   } parse_state_type;

   // Which side idles while an item is in flight.
   typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   // Kinds of rows in the directed table.
   typedef enum logic [1:0] {ROW_PLAIN, ROW_CHECKSUM, ROW_TYPED} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [7:0]   value;
      report_type   want;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_frame_function;
   logic [7:0]  rsp_frame_length;
   logic        rsp_crc_ok;
   logic [7:0]  rsp_first_payload;
   logic        rsp_battery_update;
   logic [15:0] rsp_battery_millivolts;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [7:0]  csr_data;

   // Local copy of the registers and of the parser state.
   logic            rx_on = RX_ENABLE_RESET;
   logic [7:0]      fn_limit = FUNCTION_LIMIT_RESET;
   parse_state_type phase = HUNT_FIRST;
   logic [7:0]      fn_code = '0;
   logic [7:0]      pay_len = '0;
   logic [7:0]      pay_count = '0;
   logic [7:0]      frame_crc = '0;
   logic [7:0]      pay_head [3] = '{default: '0};
   logic [15:0]     battery_mv = '0;

   report_type    report_q [$];
   idle_mode_type idle_mode = IDLE_NONE;
   int unsigned   errors = 0;
   int unsigned   bytes_sent = 0;
   int unsigned   reports_seen = 0;
   int unsigned   battery_loads = 0;
   int unsigned   settings_used = 1;

   // Directed bytes: empty frames with good and bad checksums, a broken header,
   // a function code at the limit, and a battery frame with all-ones data.
   stim_row_type stim_rows [27] = '{
      '{ROW_PLAIN, 8'hAA, '0}, '{ROW_PLAIN, 8'h55, '0}, '{ROW_PLAIN, 8'h00, '0},
      '{ROW_PLAIN, 8'h00, '0},
      '{ROW_TYPED, 8'h00, '{8'h00, 8'h00, 1'b1, 8'hFF, 1'b0, 16'h0000}},
      '{ROW_PLAIN, 8'hAA, '0}, '{ROW_PLAIN, 8'h55, '0}, '{ROW_PLAIN, 8'h00, '0},
      '{ROW_PLAIN, 8'h00, '0},
      '{ROW_TYPED, 8'h01, '{8'h00, 8'h00, 1'b0, 8'hFF, 1'b0, 16'h0000}},
      '{ROW_PLAIN, 8'hAA, '0}, '{ROW_PLAIN, 8'hAA, '0}, '{ROW_PLAIN, 8'h55, '0},
      '{ROW_PLAIN, 8'h00, '0}, '{ROW_PLAIN, 8'h00, '0}, '{ROW_PLAIN, 8'h00, '0},
      '{ROW_PLAIN, 8'hAA, '0}, '{ROW_PLAIN, 8'h55, '0}, '{ROW_PLAIN, 8'hFF, '0},
      '{ROW_PLAIN, 8'hAA, '0}, '{ROW_PLAIN, 8'h55, '0}, '{ROW_PLAIN, 8'h00, '0},
      '{ROW_PLAIN, 8'h03, '0}, '{ROW_PLAIN, 8'h04, '0}, '{ROW_PLAIN, 8'hFF, '0},
      '{ROW_PLAIN, 8'hFF, '0}, '{ROW_CHECKSUM, 8'h00, '0}
   };

   crc8_serial_frame_parser_unit u_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_rx_byte            (req_rx_byte),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_frame_function     (rsp_frame_function),
      .rsp_frame_length       (rsp_frame_length),
      .rsp_crc_ok             (rsp_crc_ok),
      .rsp_first_payload      (rsp_first_payload),
      .rsp_battery_update     (rsp_battery_update),
      .rsp_battery_millivolts (rsp_battery_millivolts),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_data               (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // CRC-8 with the reflected 0x31 polynomial, one input bit at a time.
   function automatic logic [7:0] crc8_maxim_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      logic       fb;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         fb = c[0] ^ b[i];
         c  = c >> 1;
         if (fb) c = c ^ 8'h8C;
      end
      return c;
   endfunction

   // Advances the local parser by one byte; returns 1 with the report at a checksum byte.
   function automatic bit parse_rx_byte(input logic [7:0] b, output report_type rpt);
      logic ok;
      logic upd;
      rpt = '0;
      if (!rx_on) return 1'b0;
      case (phase)
         HUNT_SECOND: begin
            phase = (b == HEADER_BYTE_TWO) ? TAKE_FUNCTION : HUNT_FIRST;
         end
         TAKE_FUNCTION: begin
            if (b < fn_limit) begin
               fn_code   = b;
               frame_crc = crc8_maxim_step(8'h00, b);
               phase     = TAKE_LENGTH;
            end else begin
               phase = HUNT_FIRST;
            end
         end
         TAKE_LENGTH: begin
            pay_len   = b;
            pay_count = '0;
            frame_crc = crc8_maxim_step(frame_crc, b);
            phase     = (b == 8'h00) ? TAKE_CHECKSUM : TAKE_PAYLOAD;
         end
         TAKE_PAYLOAD: begin
            if (pay_count < HEAD_DEPTH) pay_head[pay_count[1:0]] = b;
            frame_crc = crc8_maxim_step(frame_crc, b);
            pay_count = pay_count + 8'd1;
            if (pay_count >= pay_len) phase = TAKE_CHECKSUM;
         end
         TAKE_CHECKSUM: begin
            ok  = (b == frame_crc);
            upd = ok && fn_code == FUNCTION_SYSTEM && pay_len >= BATTERY_MIN_LEN &&
                  pay_head[0] == SUBCMD_BATTERY;
            if (upd) battery_mv = {pay_head[2], pay_head[1]};
            rpt.frame_function     = fn_code;
            rpt.frame_length       = pay_len;
            rpt.crc_ok             = ok;
            rpt.first_payload      = (pay_len != 8'h00) ? pay_head[0] : EMPTY_PAYLOAD;
            rpt.battery_update     = upd;
            rpt.battery_millivolts = battery_mv;
            phase = HUNT_FIRST;
            return 1'b1;
         end
         default: begin
            phase = (b == HEADER_BYTE_ONE) ? HUNT_SECOND : HUNT_FIRST;
         end
      endcase
      return 1'b0;
   endfunction

   // Offers one byte, waits for it to be taken, then predicts its report.
   task automatic send_byte(input logic [7:0] b, input bit typed, input report_type typed_rpt);
      report_type  rpt;
      int unsigned gap_pct;
      gap_pct = (idle_mode == IDLE_SENDER) ? 53 : (idle_mode == IDLE_BOTH) ? 11 : 0;
      @(negedge clock);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (rx_on) bytes_sent++;
      if (parse_rx_byte(b, rpt)) report_q.insert(report_q.size(), typed ? typed_rpt : rpt);
      idle_mode = idle_mode_type'((bytes_sent / 97) % 4);
   endtask

   // Mostly well-formed frames with random content, plus noise and broken headers.
   task automatic send_random_frame();
      int unsigned pick;
      logic [7:0]  fn;
      logic [7:0]  len;
      pick = $urandom_range(99);
      if (pick < 12) begin
         repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255)), 1'b0, '0);
         return;
      end
      send_byte(HEADER_BYTE_ONE, 1'b0, '0);
      if (pick < 16) begin
         send_byte(8'($urandom_range(255)), 1'b0, '0);
         return;
      end
      send_byte(HEADER_BYTE_TWO, 1'b0, '0);
      if (pick < 20) begin
         send_byte(8'($urandom_range(255, fn_limit)), 1'b0, '0);
         return;
      end
      if (fn_limit == 8'h00 || pick < 30) fn = 8'($urandom_range(255));
      else if ($urandom_range(1) == 0) fn = FUNCTION_SYSTEM;
      else fn = 8'($urandom_range(int'(fn_limit) - 1));
      // Long payloads are rare so that the run stays short.
      if ($urandom_range(99) == 0) len = 8'($urandom_range(255, 64));
      else len = 8'($urandom_range(6));
      send_byte(fn, 1'b0, '0);
      send_byte(len, 1'b0, '0);
      for (int i = 0; i < len; i++) begin
         if (i == 0 && fn == FUNCTION_SYSTEM && $urandom_range(99) < 70)
            send_byte(SUBCMD_BATTERY, 1'b0, '0);
         else
            send_byte(8'($urandom_range(255)), 1'b0, '0);
      end
      if ($urandom_range(99) < 85) send_byte(frame_crc, 1'b0, '0);
      else send_byte(8'($urandom_range(255)), 1'b0, '0);
   endtask

   task automatic run_random(input int unsigned count);
      int unsigned target;
      target = bytes_sent + count;
      while (bytes_sent < target) send_random_frame();
   endtask

   // Stops sending, waits for all expected reports, then lets the pipeline settle.
   task automatic drain_reports(input int unsigned settle);
      int unsigned guard;
      @(negedge clock);
      req_valid <= 1'b0;
      guard = 0;
      while (report_q.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (settle) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [7:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_RX_ENABLE) rx_on = data[0];
      else fn_limit = data;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Receiver stalls according to the current idle pattern.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (idle_mode == IDLE_RECEIVER) rsp_stall <= ($urandom_range(99) < 53);
         else if (idle_mode == IDLE_BOTH) rsp_stall <= ($urandom_range(99) < 11);
         else rsp_stall <= 1'b0;
      end
   end

   // Compares each accepted report with the oldest expectation.
   always @(posedge clock) begin
      report_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (report_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected report: fn=%02h len=%02h",
                                       rsp_frame_function, rsp_frame_length);
         end else begin
            want = report_q.pop_front();
            reports_seen++;
            if (rsp_battery_update === 1'b1) battery_loads++;
            if (rsp_frame_function !== want.frame_function ||
                rsp_frame_length !== want.frame_length ||
                rsp_crc_ok !== want.crc_ok ||
                rsp_first_payload !== want.first_payload ||
                rsp_battery_update !== want.battery_update ||
                rsp_battery_millivolts !== want.battery_millivolts) begin
               errors++;
               if (errors <= 10) begin
                  $display("report mismatch: want fn=%02h len=%02h ok=%0b first=%02h upd=%0b mv=%04h",
                           want.frame_function, want.frame_length, want.crc_ok,
                           want.first_payload, want.battery_update, want.battery_millivolts);
                  $display("                  got fn=%02h len=%02h ok=%0b first=%02h upd=%0b mv=%04h",
                           rsp_frame_function, rsp_frame_length, rsp_crc_ok,
                           rsp_first_payload, rsp_battery_update, rsp_battery_millivolts);
               end
            end
         end
      end
   end

   // Hard limit on the run.
   initial begin
      #5000000;
      $display("timeout with %0d reports outstanding", report_q.size());
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      logic [7:0] data;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = '0;
      csr_valid   = 1'b0;
      csr_index   = CSR_RX_ENABLE;
      csr_data    = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table at the reset settings.
      foreach (stim_rows[i]) begin
         case (stim_rows[i].kind)
            ROW_CHECKSUM: send_byte(frame_crc, 1'b0, '0);
            ROW_TYPED:    send_byte(stim_rows[i].value, 1'b1, stim_rows[i].want);
            default:      send_byte(stim_rows[i].value, 1'b0, '0);
         endcase
      end

      // Full limit, receiver on; the sender holds off halfway until all reports are in.
      drain_reports(6);
      csr_write(CSR_FUNCTION_LIMIT, 8'hFF);
      data = 8'($urandom_range(255));
      csr_write(CSR_RX_ENABLE, data | 8'h01);
      settings_used++;
      run_random(350);
      drain_reports(6);
      run_random(350);

      // A limit of zero rejects every frame.
      drain_reports(6);
      csr_write(CSR_FUNCTION_LIMIT, 8'h00);
      settings_used++;
      run_random(100);

      // Receiver off: bytes are ignored and the parser holds its state.
      drain_reports(6);
      data = 8'($urandom_range(255));
      csr_write(CSR_RX_ENABLE, data & 8'hFE);
      settings_used++;
      repeat (12) send_random_frame();

      // Only system frames pass.
      drain_reports(6);
      data = 8'($urandom_range(255));
      csr_write(CSR_RX_ENABLE, data | 8'h01);
      csr_write(CSR_FUNCTION_LIMIT, 8'h01);
      settings_used++;
      run_random(400);

      // A random limit in between.
      drain_reports(6);
      data = 8'($urandom_range(254, 2));
      csr_write(CSR_FUNCTION_LIMIT, data);
      settings_used++;
      run_random(550);

      drain_reports(8);
      if (report_q.size() != 0) begin
         errors += report_q.size();
         $display("%0d expected reports never arrived", report_q.size());
      end
      $display("Checked %0d frame reports (%0d battery loads) over %0d parsed bytes,",
               reports_seen, battery_loads, bytes_sent);
      $display("across %0d register settings and four idle patterns; %0d failures.",
               settings_used, errors);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
